// File: rtl/sklex_pkg.sv
`timescale 1ns / 1ps

package sklex_pkg;

  localparam int LineBits = 16;
  localparam int NumWords = 19;
  localparam int MaxWordLen = 8;

  localparam logic [NumWords-1:0] AllWords = {NumWords{1'b1}};

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_TOKEN = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  localparam logic [4:0] TkSemicolon = 5'd23;
  localparam logic [4:0] TkEnd       = 5'd24;
  localparam logic [4:0] TkNone      = 5'd0;

  localparam logic [7:0] ChConst     = 8'h23; // '#'
  localparam logic [7:0] ChRegister  = 8'h25; // '%'
  localparam logic [7:0] ChGlobal    = 8'h40; // '@'
  localparam logic [7:0] ChLocal     = 8'h26; // '&'
  localparam logic [7:0] ChLabel     = 8'h24; // '$'
  localparam logic [7:0] ChSemicolon = 8'h3B;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChReturn    = 8'h0D;

  // Keyword text, right-justified: the last character sits in the low byte
  localparam logic [8*MaxWordLen-1:0] WordText [NumWords] = '{
    64'("global"), 64'("define"), 64'("block"), 64'("return"), 64'("jump"),
    64'("jlt"), 64'("jeq"), 64'("call"), 64'("argument"), 64'("load"),
    64'("store"), 64'("mov"), 64'("add"), 64'("sub"), 64'("and"),
    64'("or"), 64'("neg"), 64'("not"), 64'("phi")
  };

  localparam logic [3:0] WordLen [NumWords] = '{
    4'd6, 4'd6, 4'd5, 4'd6, 4'd4, 4'd3, 4'd3, 4'd4, 4'd8, 4'd4,
    4'd5, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd3, 4'd3, 4'd3
  };

  localparam logic [4:0] WordKind [NumWords] = '{
    5'd2, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
    5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22
  };

  // Keyword matcher outputs
  typedef struct packed {
    logic [NumWords-1:0] keep;
    logic                found;
    logic [4:0]          tk;
  } match_t;

  // One result beat
  typedef struct packed {
    kind_e               kind;
    logic [7:0]          ch;
    logic [4:0]          tk;
    logic [LineBits-1:0] line;
  } result_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChReturn));
  endfunction

endpackage

// File: rtl/sigil_keyword_lexer.sv
`timescale 1ns / 1ps
// An accepted input beat passes the input register, then the lexer step
//   into the result register, before its result beat appears.
// Throughput: one character per cycle unless the output stalls; the lexer
//   step is a single pass of the 19-word compare and mask update, so back-to-back beats are taken.
// Reset (rst_ni, async, active low): start state, first_line and the line
//   counter at 1, candidate mask all ones, both registers empty.

module sigil_keyword_lexer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: first_line
  input  logic                           cfg_we_i,
  input  logic [sklex_pkg::LineBits-1:0] cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     char_in_i,
  input  logic                           end_of_input_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     kind_o,
  output logic [7:0]                     char_out_o,
  output logic [4:0]                     token_kind_o,
  output logic [sklex_pkg::LineBits-1:0] line_o
);

  // Input register. It drains into the lexer step whenever the result
  // register can take a beat, so the input stalls only while the output stalls.
  logic       in_valid_q;
  logic [7:0] char_q;
  logic       eoi_q;
  logic       can_take;
  logic       fire;

  sklex_pkg::result_t result;

  assign fire       = in_valid_q && can_take;
  assign in_stall_o = in_valid_q && !can_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      char_q     <= 8'd0;
      eoi_q      <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
      char_q     <= char_in_i;
      eoi_q      <= end_of_input_i;
    end
  end

  // Lexer state, keyword matcher and result register
  sklex_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .char_i      (char_q),
    .eoi_i       (eoi_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign kind_o       = result.kind;
  assign char_out_o   = result.ch;
  assign token_kind_o = result.tk;
  assign line_o       = result.line;

endmodule

// File: rtl/sklex_match.sv
`timescale 1ns / 1ps

module sklex_match (
  input  logic [7:0]                     char_i,
  input  logic [3:0]                     len_i,
  input  logic [sklex_pkg::NumWords-1:0] mask_i,
  output sklex_pkg::match_t              match_o
);

  // Per-word compare of the next character, plus length/mask resolve
  always_comb begin
    logic [3:0] pos;
    logic [7:0] wc;
    match_o = '0;
    for (int i = 0; i < sklex_pkg::NumWords; i++) begin
      pos = sklex_pkg::WordLen[i] - 4'd1 - len_i;
      wc  = sklex_pkg::WordText[i][{pos[2:0], 3'b000} +: 8];
      match_o.keep[i] = mask_i[i] && (len_i < sklex_pkg::WordLen[i]) && (wc == char_i);
      if (mask_i[i] && (sklex_pkg::WordLen[i] == len_i)) begin
        match_o.found = 1'b1;
        match_o.tk    = sklex_pkg::WordKind[i];
      end
    end
  end

endmodule

// File: rtl/sklex_fsm.sv
`timescale 1ns / 1ps

module sklex_fsm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic [7:0]                      char_i,
  input  logic                            eoi_i,
  input  logic                            cfg_we_i,
  input  logic [sklex_pkg::LineBits-1:0]  cfg_wdata_i,
  input  logic                            out_stall_i,
  output logic                            can_take_o,
  output logic                            out_valid_o,
  output sklex_pkg::result_t              result_o
);

  typedef enum logic [2:0] {
    ST_START    = 3'd0,
    ST_CONST    = 3'd1,
    ST_REGISTER = 3'd2,
    ST_GLOBAL   = 3'd3,
    ST_LOCAL    = 3'd4,
    ST_LABEL    = 3'd5,
    ST_KEYWORD  = 3'd6
  } state_e;

  state_e                        state_q, state_d;
  logic [sklex_pkg::LineBits-1:0] first_q, first_d;
  logic [sklex_pkg::LineBits-1:0] lcnt_q, lcnt_d;
  logic [sklex_pkg::LineBits-1:0] tline_q, tline_d;
  logic [sklex_pkg::NumWords-1:0] mask_q, mask_d;
  logic [3:0]                     len_q, len_d;
  logic                           out_valid_q, out_valid_d;
  sklex_pkg::result_t             res_q, res_d;

  logic                           in_start;
  logic [sklex_pkg::NumWords-1:0] eff_mask;
  logic [3:0]                     eff_len;
  logic [3:0]                     len_inc;
  sklex_pkg::match_t              match;

  assign in_start = (state_q == ST_START) || (state_q == 3'd7);
  assign eff_mask = in_start ? sklex_pkg::AllWords : mask_q;
  assign eff_len  = in_start ? 4'd0 : len_q;
  assign len_inc  = (eff_len == 4'd15) ? 4'd15 : eff_len + 4'd1;

  sklex_match u_match (
    .char_i  (char_i),
    .len_i   (eff_len),
    .mask_i  (eff_mask),
    .match_o (match)
  );

  assign can_take_o  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    lcnt_d      = lcnt_q;
    tline_d     = tline_q;
    mask_d      = mask_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;

    if (fire_i) begin
      out_valid_d = 1'b0;
      res_d       = '0;
      if (eoi_i) begin
        out_valid_d = 1'b1;
        res_d.kind  = sklex_pkg::KIND_END;
        res_d.tk    = sklex_pkg::TkEnd;
        res_d.line  = lcnt_q;
        state_d     = ST_START;
        mask_d      = sklex_pkg::AllWords;
        len_d       = 4'd0;
        lcnt_d      = first_q;
      end else begin
        if (char_i == sklex_pkg::ChNewline) begin
          lcnt_d = lcnt_q + 1'b1;
        end
        if (in_start) begin
          state_d = ST_START;
          mask_d  = sklex_pkg::AllWords;
          len_d   = 4'd0;
          priority if (char_i == sklex_pkg::ChConst) begin
            state_d = ST_CONST;
            tline_d = lcnt_q;
          end else if (char_i == sklex_pkg::ChRegister) begin
            state_d = ST_REGISTER;
            tline_d = lcnt_q;
          end else if (char_i == sklex_pkg::ChGlobal) begin
            state_d = ST_GLOBAL;
            tline_d = lcnt_q;
          end else if (char_i == sklex_pkg::ChLocal) begin
            state_d = ST_LOCAL;
            tline_d = lcnt_q;
          end else if (char_i == sklex_pkg::ChLabel) begin
            state_d = ST_LABEL;
            tline_d = lcnt_q;
          end else if (char_i == sklex_pkg::ChSemicolon) begin
            out_valid_d = 1'b1;
            res_d.kind  = sklex_pkg::KIND_TOKEN;
            res_d.tk    = sklex_pkg::TkSemicolon;
            res_d.line  = lcnt_q;
          end else if (sklex_pkg::is_white(char_i)) begin
            state_d = ST_START;
          end else begin
            state_d     = ST_KEYWORD;
            tline_d     = lcnt_q;
            mask_d      = match.keep;
            len_d       = len_inc;
            out_valid_d = 1'b1;
            res_d.kind  = sklex_pkg::KIND_CHAR;
            res_d.ch    = char_i;
          end
        end else if (!sklex_pkg::is_white(char_i)) begin
          tline_d = lcnt_q;
          if (state_q == ST_KEYWORD) begin
            mask_d = match.keep;
            len_d  = len_inc;
          end
          out_valid_d = 1'b1;
          res_d.kind  = sklex_pkg::KIND_CHAR;
          res_d.ch    = char_i;
        end else begin
          // whitespace closes the token
          out_valid_d = 1'b1;
          res_d.line  = tline_q;
          if (state_q == ST_KEYWORD) begin
            if (match.found) begin
              res_d.kind = sklex_pkg::KIND_TOKEN;
              res_d.tk   = match.tk;
            end else begin
              res_d.kind = sklex_pkg::KIND_ERROR;
            end
          end else begin
            res_d.kind = sklex_pkg::KIND_TOKEN;
            res_d.tk   = 5'(state_q) - 5'd1;
          end
          state_d = ST_START;
          mask_d  = sklex_pkg::AllWords;
          len_d   = 4'd0;
        end
      end
    end else if (cfg_we_i) begin
      first_d = cfg_wdata_i;
      lcnt_d  = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      first_q     <= sklex_pkg::LineBits'(1);
      lcnt_q      <= sklex_pkg::LineBits'(1);
      tline_q     <= '0;
      mask_q      <= sklex_pkg::AllWords;
      len_q       <= 4'd0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      lcnt_q      <= lcnt_d;
      tline_q     <= tline_d;
      mask_q      <= mask_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

endmodule
